FILE: src/scr_pkg.sv
// ----------------------------------------------------------------------------
// Sequential switch router package
// Shared types, register indexes and constants for the crossfade router.
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int GAIN_W     = 17;
    localparam int GAIN_FRAC  = 16;
    localparam int LFSR_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    localparam logic [GAIN_W-1:0] FULL_GAIN = 17'h10000;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DIRECTION   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TARGET     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ON_RESET = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PRESENT    = 4'd7;

    localparam logic [1:0] DIR_INC  = 2'd0;
    localparam logic [1:0] DIR_RAND = 2'd1;
    localparam logic [1:0] DIR_DEC  = 2'd2;

    localparam logic MODE_CV      = 1'b0;
    localparam logic MODE_TRIGGER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESET_EV,
        ST_CTRL_EV,
        ST_SWEEP
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_UP,
        OP_DOWN,
        OP_RAND
    } step_op_t;

    typedef struct packed {
        logic                select_mode;
        logic [1:0]          step_direction;
        logic [3:0]          output_count;
        logic [GAIN_W-1:0]   fade_step;
        logic [2:0]          reset_target;
        logic                wrap_enable;
        logic                reverse_on_reset;
        logic                right_present;
    } cfg_t;

    function automatic step_op_t dir_to_op(logic [1:0] dir, logic reverse);
        step_op_t op;
        case (dir)
            DIR_INC:  op = reverse ? OP_DOWN : OP_UP;
            DIR_DEC:  op = reverse ? OP_UP : OP_DOWN;
            DIR_RAND: op = OP_RAND;
            default:  op = OP_HOLD;
        endcase
        return op;
    endfunction

endpackage

FILE: src/scr_gain_ram.sv
// ----------------------------------------------------------------------------
// Gain memory
// One gain per output; synchronous read, one write port, per-entry valid bits
// so that unwritten entries read as full gain.
// ----------------------------------------------------------------------------
module scr_gain_ram #(
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [scr_pkg::GAIN_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [scr_pkg::GAIN_W-1:0] wr_data
);
    import scr_pkg::*;

    logic [GAIN_W-1:0] mem [DEPTH];
    logic [GAIN_W-1:0] rd_q_reg;
    logic [DEPTH-1:0]  vld_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : FULL_GAIN;

endmodule

FILE: src/scr_step.sv
// ----------------------------------------------------------------------------
// Output stepper
// Next output for one step event: up, down, random draw or hold.
// ----------------------------------------------------------------------------
module scr_step #(
    parameter int NUM_OUTPUTS = 8,
    localparam int IDX_W = $clog2(NUM_OUTPUTS),
    localparam int CNT_W = $clog2(NUM_OUTPUTS + 1)
) (
    input  logic [IDX_W-1:0]           cur,
    input  logic [CNT_W-1:0]           cnt,
    input  scr_pkg::step_op_t          op,
    input  logic                       wrap,
    input  logic [scr_pkg::LFSR_W-1:0] lfsr,
    output logic [scr_pkg::LFSR_W-1:0] lfsr_adv,
    output logic [IDX_W-1:0]           nxt
);
    import scr_pkg::*;

    localparam int UW = CNT_W + 1;
    localparam int RW = LFSR_W + CNT_W;

    logic [RW-1:0]    rnd_prod;
    logic [IDX_W-1:0] rnd_idx;
    logic [IDX_W-1:0] up_idx;
    logic [IDX_W-1:0] down_idx;
    logic [CNT_W-1:0] top_idx;

    assign lfsr_adv = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
    assign rnd_prod = RW'(lfsr_adv) * RW'(cnt);
    assign rnd_idx  = rnd_prod[LFSR_W +: IDX_W];
    assign top_idx  = cnt - CNT_W'(1);

    always_comb
    begin
        if ((UW'(cur) + UW'(2)) > UW'(cnt))
        begin
            up_idx = wrap ? '0 : cur;
        end
        else
        begin
            up_idx = cur + IDX_W'(1);
        end

        if (cur == '0)
        begin
            down_idx = wrap ? top_idx[IDX_W-1:0] : cur;
        end
        else
        begin
            down_idx = cur - IDX_W'(1);
        end

        case (op)
            OP_UP:   nxt = up_idx;
            OP_DOWN: nxt = down_idx;
            OP_RAND: nxt = rnd_idx;
            default: nxt = cur;
        endcase
    end

endmodule

FILE: src/scr_scale.sv
// ----------------------------------------------------------------------------
// Output scaler
// Multiply the stereo pair by a gain, round and hold the result beat in the
// master-side output register.
// ----------------------------------------------------------------------------
module scr_scale #(
    parameter int NUM_OUTPUTS = 8,
    parameter int SAMPLE_BITS = 16,
    localparam int IDX_W  = $clog2(NUM_OUTPUTS),
    localparam int OUT_DW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              adv,
    input  logic signed [SAMPLE_BITS-1:0]     left,
    input  logic signed [SAMPLE_BITS-1:0]     right,
    input  logic [scr_pkg::GAIN_W-1:0]        gain,
    input  logic [IDX_W-1:0]                  idx,
    input  logic                              sel,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_DW-1:0]                 m_tdata,   // left_out, right_out
    output logic [3:0]                        m_tuser,   // out_index[2:0], is_selected
    output logic                              m_tlast
);
    import scr_pkg::*;

    localparam int PW = SAMPLE_BITS + GAIN_W + 1;
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] NEG_FS   =
        {1'b1, {(SAMPLE_BITS-2){1'b0}}, 1'b1};

    logic signed [SAMPLE_BITS-1:0] left_c;
    logic signed [SAMPLE_BITS-1:0] right_c;
    logic signed [GAIN_W:0]        gain_s;
    logic signed [PW-1:0]          prod_l_next;
    logic signed [PW-1:0]          prod_r_next;
    logic signed [PW-1:0]          sum_l;
    logic signed [PW-1:0]          sum_r;

    logic                          p2_valid_reg;
    logic signed [PW-1:0]          p2_prod_l_reg;
    logic signed [PW-1:0]          p2_prod_r_reg;
    logic [IDX_W-1:0]              p2_idx_reg;
    logic                          p2_sel_reg;

    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_left_reg;
    logic [SAMPLE_BITS-1:0]        out_right_reg;
    logic [2:0]                    out_idx_reg;
    logic                          out_sel_reg;
    logic                          out_last_reg;

    assign adv     = !out_valid_reg || m_tready;
    assign left_c  = (left == MOST_NEG) ? NEG_FS : left;
    assign right_c = (right == MOST_NEG) ? NEG_FS : right;
    assign gain_s  = $signed({1'b0, gain});

    assign prod_l_next = PW'(left_c) * PW'(gain_s);
    assign prod_r_next = PW'(right_c) * PW'(gain_s);

    assign sum_l = p2_prod_l_reg + PW'(1 << (GAIN_FRAC - 1));
    assign sum_r = p2_prod_r_reg + PW'(1 << (GAIN_FRAC - 1));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_prod_l_reg <= prod_l_next;
            p2_prod_r_reg <= prod_r_next;
            p2_idx_reg    <= idx;
            p2_sel_reg    <= sel;
            out_left_reg  <= sum_l[GAIN_FRAC +: SAMPLE_BITS];
            out_right_reg <= sum_r[GAIN_FRAC +: SAMPLE_BITS];
            out_idx_reg   <= 3'(p2_idx_reg);
            out_sel_reg   <= p2_sel_reg;
            out_last_reg  <= (p2_idx_reg == IDX_W'(NUM_OUTPUTS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p2_valid_reg  <= in_valid;
            out_valid_reg <= p2_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'({out_right_reg, out_left_reg});
    assign m_tuser  = {out_sel_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: src/sequential_switch_crossfade_router_top.sv
// Each input beat runs the reset and control event states, then the gain sweep,
// whose results pass the p1, p2 and output registers. Throughput: NUM_OUTPUTS
// result beats, one per cycle unless the output stalls; a new input beat waits
// for the gain memory sweep, one read-modify-write per cycle unless stalled.
// Reset: asynchronous, active low; gains read as full gain until written,
// no clearing pass, so the block accepts input as soon as reset is released.
// ----------------------------------------------------------------------------
// Sequential switch crossfade router
// Routes a stereo sample to one of several outputs selected by trigger steps,
// a reset edge or CV level; a nonzero fade step ramps per-output gains on change.
// ----------------------------------------------------------------------------
module sequential_switch_crossfade_router_top #(
    parameter int NUM_OUTPUTS = 8,
    parameter int SAMPLE_BITS = 16,
    localparam int IN_DW  = ((4 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // control_level, reset_level, left_sample, right_sample
    input  logic [IN_DW-1:0]                    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_out, right_out
    output logic [OUT_DW-1:0]                   m_tdata,
    // out_index[2:0], is_selected
    output logic [3:0]                          m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import scr_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int IDX_W     = $clog2(NUM_OUTPUTS);
    localparam int CNT_W     = $clog2(NUM_OUTPUTS + 1);
    localparam int SAMPLE_FS = (1 << (SB - 1)) - 1;
    localparam int PRW       = SB - 1 + CNT_W;
    localparam logic signed [SB-1:0] LEVEL_HIGH = SB'(SAMPLE_FS / 10);

    cfg_t                   cfg_reg, cfg_next;
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]       last_cv_slot_reg, last_cv_slot_next;
    logic                   fade_in_active_reg, fade_in_active_next;
    logic [IDX_W-1:0]       fade_in_output_reg, fade_in_output_next;
    logic [NUM_OUTPUTS-1:0] fade_out_reg, fade_out_next;
    logic [NUM_OUTPUTS-1:0] full_mask_reg, full_mask_next;
    logic signed [SB-1:0]   last_ctrl_reg, last_ctrl_next;
    logic signed [SB-1:0]   last_rst_reg, last_rst_next;
    logic [LFSR_W-1:0]      lfsr_reg, lfsr_next;
    logic [IDX_W-1:0]       sweep_idx_reg, sweep_idx_next;
    logic                   p1_valid_reg, p1_valid_next;
    logic [IDX_W-1:0]       p1_idx_reg, p1_idx_next;

    logic signed [SB-1:0]   ctrl_in_reg;
    logic signed [SB-1:0]   rst_in_reg;
    logic signed [SB-1:0]   left_in_reg;
    logic signed [SB-1:0]   right_in_reg;
    logic [PRW-1:0]         cv_prod_reg, cv_prod_next;

    logic                   in_beat;
    logic [4:0]             cnt5;
    logic [CNT_W-1:0]       eff_cnt;
    logic [4:0]             tgt5;
    logic [IDX_W-1:0]       tgt_idx;
    logic                   rst_edge;
    logic                   ctrl_edge;
    logic [SB-2:0]          cv_lvl;
    logic signed [SB-1:0]   cv_lvl_s;
    logic [CNT_W-1:0]       slot;
    logic [IDX_W-1:0]       slot_idx;
    logic                   rev_path;
    step_op_t               step_op;
    logic [IDX_W-1:0]       step_idx;
    logic [LFSR_W-1:0]      lfsr_adv;
    logic                   chg;
    logic [IDX_W-1:0]       new_cur;

    logic                   adv;
    logic                   rd_en;
    logic [GAIN_W-1:0]      rd_gain;
    logic                   wr_en;
    logic [GAIN_W-1:0]      g_in;
    logic [GAIN_W:0]        g_up;
    logic [GAIN_W-1:0]      gain_use;
    logic [GAIN_W-1:0]      gain_new;
    logic                   fade_in_done;
    logic                   fade_out_done;
    logic                   p1_is_cur;
    logic signed [SB-1:0]   right_src;

    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            ctrl_in_reg  <= s_tdata[0 +: SB];
            rst_in_reg   <= s_tdata[SB +: SB];
            left_in_reg  <= s_tdata[2*SB +: SB];
            right_in_reg <= s_tdata[3*SB +: SB];
        end
        cv_prod_reg <= cv_prod_next;
    end

    assign cnt5 = (cfg_reg.output_count == 4'd0) ? 5'd1 :
                  (({1'b0, cfg_reg.output_count} > 5'(NUM_OUTPUTS)) ? 5'(NUM_OUTPUTS) :
                   {1'b0, cfg_reg.output_count});
    assign eff_cnt = cnt5[CNT_W-1:0];

    assign tgt5 = ({2'b00, cfg_reg.reset_target} < 5'(NUM_OUTPUTS)) ?
                  {2'b00, cfg_reg.reset_target} : 5'(NUM_OUTPUTS - 1);
    assign tgt_idx = tgt5[IDX_W-1:0];

    assign rst_edge  = (rst_in_reg > LEVEL_HIGH) && !(last_rst_reg > LEVEL_HIGH);
    assign ctrl_edge = (ctrl_in_reg > LEVEL_HIGH) && !(last_ctrl_reg > LEVEL_HIGH);

    assign cv_lvl       = ctrl_in_reg[SB-1] ? '0 : ctrl_in_reg[SB-2:0];
    assign cv_lvl_s     = $signed({1'b0, cv_lvl});
    assign cv_prod_next = PRW'(cv_lvl) * PRW'(eff_cnt);

    always_comb
    begin
        slot = '0;
        for (int k = 1; k <= NUM_OUTPUTS; k++)
        begin
            if (cv_prod_reg >= PRW'(k * SAMPLE_FS))
            begin
                slot = CNT_W'(k);
            end
        end
        if (slot >= eff_cnt)
        begin
            slot = eff_cnt - CNT_W'(1);
        end
    end
    assign slot_idx = slot[IDX_W-1:0];

    assign rev_path = cfg_reg.reverse_on_reset && (cfg_reg.select_mode == MODE_TRIGGER);
    assign step_op  = (state_reg == ST_RESET_EV) ?
                      (rev_path ? dir_to_op(cfg_reg.step_direction, 1'b1) : OP_HOLD) :
                      dir_to_op(cfg_reg.step_direction, 1'b0);

    scr_step #(
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_step (
        .cur      (cur_reg),
        .cnt      (eff_cnt),
        .op       (step_op),
        .wrap     (cfg_reg.wrap_enable),
        .lfsr     (lfsr_reg),
        .lfsr_adv (lfsr_adv),
        .nxt      (step_idx)
    );

    scr_gain_ram #(
        .DEPTH (NUM_OUTPUTS)
    ) u_gain_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (sweep_idx_reg),
        .rd_data (rd_gain),
        .wr_en   (wr_en),
        .wr_addr (p1_idx_reg),
        .wr_data (gain_new)
    );

    always_comb
    begin
        p1_is_cur     = (p1_idx_reg == cur_reg);
        g_in          = full_mask_reg[p1_idx_reg] ? FULL_GAIN : rd_gain;
        g_up          = {1'b0, g_in} + {1'b0, cfg_reg.fade_step};
        fade_in_done  = 1'b0;
        fade_out_done = 1'b0;
        gain_use      = '0;
        gain_new      = g_in;
        if (p1_is_cur)
        begin
            if (fade_in_active_reg && (fade_in_output_reg == p1_idx_reg))
            begin
                if (g_up > {1'b0, FULL_GAIN})
                begin
                    gain_new     = FULL_GAIN;
                    fade_in_done = 1'b1;
                end
                else
                begin
                    gain_new = g_up[GAIN_W-1:0];
                end
            end
            gain_use = gain_new;
        end
        else if (fade_out_reg[p1_idx_reg])
        begin
            gain_use = g_in;
            if (cfg_reg.fade_step > g_in)
            begin
                gain_new      = '0;
                fade_out_done = 1'b1;
            end
            else
            begin
                gain_new = g_in - cfg_reg.fade_step;
            end
        end
    end

    always_comb
    begin
        cfg_next            = cfg_reg;
        state_next          = state_reg;
        cur_next            = cur_reg;
        last_cv_slot_next   = last_cv_slot_reg;
        fade_in_active_next = fade_in_active_reg;
        fade_in_output_next = fade_in_output_reg;
        fade_out_next       = fade_out_reg;
        full_mask_next      = full_mask_reg;
        last_ctrl_next      = last_ctrl_reg;
        last_rst_next       = last_rst_reg;
        lfsr_next           = lfsr_reg;
        sweep_idx_next      = sweep_idx_reg;
        p1_valid_next       = p1_valid_reg;
        p1_idx_next         = p1_idx_reg;
        s_tready            = 1'b0;
        rd_en               = 1'b0;
        wr_en               = 1'b0;
        chg                 = 1'b0;
        new_cur             = cur_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SELECT_MODE:      cfg_next.select_mode      = cfg_data[0];
                REG_STEP_DIRECTION:   cfg_next.step_direction   = cfg_data[1:0];
                REG_OUTPUT_COUNT:     cfg_next.output_count     = cfg_data[3:0];
                REG_FADE_STEP:        cfg_next.fade_step        = cfg_data[GAIN_W-1:0];
                REG_RESET_TARGET:     cfg_next.reset_target     = cfg_data[2:0];
                REG_WRAP_ENABLE:      cfg_next.wrap_enable      = cfg_data[0];
                REG_REVERSE_ON_RESET: cfg_next.reverse_on_reset = cfg_data[0];
                REG_RIGHT_PRESENT:    cfg_next.right_present    = cfg_data[0];
                default:              ;
            endcase
        end

        if (adv)
        begin
            p1_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = !p1_valid_reg;
                if (s_tvalid && !p1_valid_reg)
                begin
                    full_mask_next = '0;
                    state_next     = ST_RESET_EV;
                end
            end
            ST_RESET_EV:
            begin
                last_rst_next = rst_in_reg;
                if (rst_edge)
                begin
                    chg     = 1'b1;
                    new_cur = rev_path ? step_idx : tgt_idx;
                end
                state_next = ST_CTRL_EV;
            end
            ST_CTRL_EV:
            begin
                if (cfg_reg.select_mode == MODE_TRIGGER)
                begin
                    if (ctrl_edge)
                    begin
                        chg     = 1'b1;
                        new_cur = step_idx;
                    end
                    last_ctrl_next = ctrl_in_reg;
                end
                else
                begin
                    if ((cv_lvl_s != last_ctrl_reg) && (slot_idx != last_cv_slot_reg))
                    begin
                        chg               = 1'b1;
                        new_cur           = slot_idx;
                        last_cv_slot_next = slot_idx;
                    end
                    last_ctrl_next = cv_lvl_s;
                end
                sweep_idx_next = '0;
                state_next     = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (adv)
                begin
                    rd_en         = 1'b1;
                    p1_valid_next = 1'b1;
                    p1_idx_next   = sweep_idx_reg;
                    if (sweep_idx_reg == IDX_W'(NUM_OUTPUTS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (chg)
        begin
            cur_next = new_cur;
            if (step_op == OP_RAND && !(state_reg == ST_CTRL_EV &&
                cfg_reg.select_mode == MODE_CV))
            begin
                lfsr_next = lfsr_adv;
            end
            if (cfg_reg.fade_step == '0)
            begin
                full_mask_next[new_cur] = 1'b1;
            end
            else
            begin
                fade_in_active_next    = 1'b1;
                fade_in_output_next    = new_cur;
                fade_out_next[cur_reg] = 1'b1;
            end
        end

        if (p1_valid_reg && adv)
        begin
            wr_en = 1'b1;
            if (fade_in_done)
            begin
                fade_in_active_next = 1'b0;
            end
            if (fade_out_done)
            begin
                fade_out_next[p1_idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.select_mode      <= MODE_TRIGGER;
            cfg_reg.step_direction   <= DIR_INC;
            cfg_reg.output_count     <= 4'd8;
            cfg_reg.fade_step        <= '0;
            cfg_reg.reset_target     <= 3'd0;
            cfg_reg.wrap_enable      <= 1'b1;
            cfg_reg.reverse_on_reset <= 1'b0;
            cfg_reg.right_present    <= 1'b0;
            state_reg                <= ST_IDLE;
            cur_reg                  <= '0;
            last_cv_slot_reg         <= '0;
            fade_in_active_reg       <= 1'b0;
            fade_in_output_reg       <= '0;
            fade_out_reg             <= '0;
            full_mask_reg            <= '0;
            last_ctrl_reg            <= '0;
            last_rst_reg             <= '0;
            lfsr_reg                 <= LFSR_SEED;
            sweep_idx_reg            <= '0;
            p1_valid_reg             <= 1'b0;
            p1_idx_reg               <= '0;
        end
        else
        begin
            cfg_reg            <= cfg_next;
            state_reg          <= state_next;
            cur_reg            <= cur_next;
            last_cv_slot_reg   <= last_cv_slot_next;
            fade_in_active_reg <= fade_in_active_next;
            fade_in_output_reg <= fade_in_output_next;
            fade_out_reg       <= fade_out_next;
            full_mask_reg      <= full_mask_next;
            last_ctrl_reg      <= last_ctrl_next;
            last_rst_reg       <= last_rst_next;
            lfsr_reg           <= lfsr_next;
            sweep_idx_reg      <= sweep_idx_next;
            p1_valid_reg       <= p1_valid_next;
            p1_idx_reg         <= p1_idx_next;
        end
    end

    assign right_src = cfg_reg.right_present ? right_in_reg : left_in_reg;

    scr_scale #(
        .NUM_OUTPUTS (NUM_OUTPUTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p1_valid_reg),
        .adv      (adv),
        .left     (left_in_reg),
        .right    (right_src),
        .gain     (gain_use),
        .idx      (p1_idx_reg),
        .sel      (p1_is_cur),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_accept_starts_events: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_RESET_EV))
        else $error("input beat did not start event handling");

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= IDX_W'(NUM_OUTPUTS - 1))
        else $error("current output out of range");

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("random generator stuck at zero");

    a_gain_write_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (gain_new <= FULL_GAIN))
        else $error("gain written above full scale");

    a_no_accept_while_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |=> !$past(in_beat))
        else $error("input beat taken during gain sweep");
`endif

endmodule
